// ----- rtl/mwg_pkg.sv -----
// ----------------------------------------------------------------------------
// mwg_pkg: shared types and constants of the multichannel waveform generator
// Register indexes, wave mode codes, widths and the quarter sine table.
// ----------------------------------------------------------------------------
package mwg_pkg;

  // Channel count and field widths
  localparam int MAX_CHANNELS    = 8;
  localparam int CH_W            = 3;
  localparam int CNT_W           = 4;
  localparam int AMP_W           = 16;
  localparam int SAMPLE_W        = 17;
  localparam int MODE_W          = 3;
  localparam int CFG_IDX_W       = 2;
  localparam int CFG_DATA_W      = 32;

  // Phase and sine table geometry
  localparam int PHASE_BITS      = 32;
  localparam int SINE_TABLE_BITS = 10;
  localparam int QUARTER_BITS    = SINE_TABLE_BITS - 2;
  localparam int QUARTER         = 1 << QUARTER_BITS;
  localparam int QADDR_W         = QUARTER_BITS + 1;
  localparam int ENTRY_W         = 15;
  localparam int PROD_W          = PHASE_BITS + SAMPLE_W;

  // Channel phase offset: round(2^PHASE_BITS / (2*pi))
  localparam longint unsigned INV_TWO_PI_48 = 64'd44798133900177;
  localparam logic [PHASE_BITS-1:0] CH_OFFSET =
    PHASE_BITS'((INV_TWO_PI_48 + (64'd1 << (47 - PHASE_BITS))) >> (48 - PHASE_BITS));

  // Noise LFSR tap mask, right-shifting Galois form
  localparam logic [31:0] NOISE_MASK = 32'h8020_0003;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_WAVE_MODE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_AMPLITUDE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PHASE_STEP = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CHANNELS  = 2'd3;

  // Wave modes
  localparam logic [MODE_W-1:0] MODE_NOISE  = 3'd0;
  localparam logic [MODE_W-1:0] MODE_SINE   = 3'd1;
  localparam logic [MODE_W-1:0] MODE_COSINE = 3'd2;
  localparam logic [MODE_W-1:0] MODE_FLAT   = 3'd3;
  localparam logic [MODE_W-1:0] MODE_SAW    = 3'd4;
  localparam logic [MODE_W-1:0] MODE_SQUARE = 3'd5;

  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

  typedef logic [ENTRY_W-1:0] qtab_t [QUARTER+1];

  // First-quadrant sine in Q15, Taylor series in Q30, evaluated at elaboration
  function automatic qtab_t build_qtab();
    qtab_t          t;
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint          sum;
    for (int r = 0; r <= QUARTER; r++) begin
      x    = (HALF_PI_Q30 * longint'(r)) >> QUARTER_BITS;
      x2   = (x * x) >> 30;
      term = x;
      sum  = longint'(x);
      term = ((term * x2) >> 30) / 6;   sum = sum - longint'(term);
      term = ((term * x2) >> 30) / 20;  sum = sum + longint'(term);
      term = ((term * x2) >> 30) / 42;  sum = sum - longint'(term);
      term = ((term * x2) >> 30) / 72;  sum = sum + longint'(term);
      term = ((term * x2) >> 30) / 110; sum = sum - longint'(term);
      term = ((term * x2) >> 30) / 156; sum = sum + longint'(term);
      if (sum < 0) sum = 0;
      if (sum > (64'sd1 <<< 30)) sum = 64'sd1 <<< 30;
      t[r] = ENTRY_W'((sum * 32767 + (64'sd1 <<< 29)) >>> 30);
    end
    return t;
  endfunction

  localparam qtab_t SINE_QTAB = build_qtab();

endpackage

// ----- rtl/multichannel_waveform_generator.sv -----
// ----------------------------------------------------------------------------
// multichannel_waveform_generator: DDS waveform source, one word per channel
// Each slice request yields one sample for every active channel, then steps
// the phase accumulator. Noise, sine, cosine, flat, sawtooth and square.
// ----------------------------------------------------------------------------
//
//  channel | direction | words                           | handshake
//  --------+-----------+---------------------------------+--------------
//  in_     | in        | slice_request                   | valid / stall
//  out_    | out       | channel_index, sample_value,    | valid / stall
//          |           | last_of_slice                   |
//  cfg_    | in        | register index + data           | write enable
//
// One output word per cycle while out_stall is low; a slice of n channels
// issues them in turn, and the next request is taken on the cycle its last
// channel issues. An issued channel passes the table read, multiply and
// sample forming registers before out_valid. The sine quadrant table is a
// registered ROM. Reset is synchronous; no clearing pass. out_stall holds the
// whole pipe.
module multichannel_waveform_generator (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              in_slice_request,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [mwg_pkg::CH_W-1:0]          out_channel_index,
  output logic signed [mwg_pkg::SAMPLE_W-1:0] out_sample_value,
  output logic                              out_last_of_slice,
  input  logic                              cfg_write_en,
  input  logic [mwg_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [mwg_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import mwg_pkg::*;

  // Configuration registers
  logic [MODE_W-1:0]     mode_r;
  logic [AMP_W-1:0]      amp_r;
  logic [PHASE_BITS-1:0] step_r;
  logic [CNT_W-1:0]      chans_r;

  // Slice sequencer
  logic                  busy_r;
  logic [CH_W-1:0]       cnt_r;
  logic [CH_W-1:0]       nlast_r;
  logic [PHASE_BITS-1:0] acc_r;
  logic [PHASE_BITS-1:0] slice_phase_r;
  logic [PHASE_BITS-1:0] ch_phase_r;
  logic [31:0]           lfsr_r;

  // Pipeline stage 1
  logic                  s1_valid_r;
  logic [CH_W-1:0]       s1_ch_r;
  logic                  s1_last_r;
  logic                  s1_neg_r;
  logic [PHASE_BITS-1:0] s1_phase_r;
  logic [PHASE_BITS-1:0] s1_opa_r;
  logic [ENTRY_W-1:0]    rom_q_r;

  // Pipeline stage 2
  logic                  s2_valid_r;
  logic [CH_W-1:0]       s2_ch_r;
  logic                  s2_last_r;
  logic                  s2_neg_r;
  logic [PHASE_BITS-1:0] s2_phase_r;
  logic [PROD_W-1:0]     s2_prod_r;

  // Output register
  logic                       out_valid_r;
  logic [CH_W-1:0]            out_ch_r;
  logic signed [SAMPLE_W-1:0] out_sample_r;
  logic                       out_last_r;

  logic                  adv;
  logic                  issue;
  logic                  issue_last;
  logic                  in_acc;
  logic                  start;
  logic [CNT_W-1:0]      n_clamped;
  logic [31:0]           lfsr_nxt;
  logic [PHASE_BITS-1:0] sin_phase;
  logic [SINE_TABLE_BITS-1:0] tab_idx;
  logic [QADDR_W-1:0]    rom_addr;
  logic [PHASE_BITS-1:0] mul_a;
  logic [SAMPLE_W-1:0]   mul_b;
  logic [PHASE_BITS-1:0] half_phase;
  logic [SAMPLE_W-1:0]   sine_mag;
  logic [SAMPLE_W-1:0]   sine_mag_up;
  logic signed [SAMPLE_W:0] noise_wide;
  logic signed [SAMPLE_W-1:0] sample_nxt;

  // Handshake and pipeline advance
  assign adv        = !(out_valid_r && out_stall);
  assign issue      = busy_r && adv;
  assign issue_last = issue && (cnt_r == nlast_r);
  assign in_stall   = busy_r && !issue_last;
  assign in_acc     = in_valid && !in_stall;
  assign start      = in_acc && in_slice_request;

  // Channel count clamp: 0 counts as 1, above the maximum as the maximum
  always_comb begin
    n_clamped = chans_r;
    if (chans_r == '0) n_clamped = CNT_W'(1);
    if (chans_r > CNT_W'(MAX_CHANNELS)) n_clamped = CNT_W'(MAX_CHANNELS);
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_NOISE;
      amp_r   <= AMP_W'(1);
      step_r  <= '0;
      chans_r <= CNT_W'(1);
    end else if (cfg_write_en) begin
      case (cfg_index)
        REG_WAVE_MODE:  mode_r  <= cfg_data[MODE_W-1:0];
        REG_AMPLITUDE:  amp_r   <= cfg_data[AMP_W-1:0];
        REG_PHASE_STEP: step_r  <= cfg_data[PHASE_BITS-1:0];
        REG_CHANNELS:   chans_r <= cfg_data[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Sequencer: start a slice, then walk the channels one a cycle unless stalled
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      acc_r  <= '0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r        <= 1'b1;
      cnt_r         <= '0;
      nlast_r       <= CH_W'(n_clamped - CNT_W'(1));
      slice_phase_r <= acc_r;
      ch_phase_r    <= acc_r;
      acc_r         <= acc_r + step_r;
    end else if (issue) begin
      if (issue_last) busy_r <= 1'b0;
      cnt_r      <= cnt_r + CH_W'(1);
      ch_phase_r <= ch_phase_r + CH_OFFSET;
    end
  end

  // Noise LFSR, stepped once per noise sample
  assign lfsr_nxt = (lfsr_r >> 1) ^ (lfsr_r[0] ? NOISE_MASK : 32'd0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lfsr_r <= 32'd1;
    end else if (issue && (mode_r == MODE_NOISE)) begin
      lfsr_r <= lfsr_nxt;
    end
  end

  // Table address: quadrant folding, cosine is a quarter cycle ahead
  assign sin_phase = (mode_r == MODE_COSINE) ?
                     ch_phase_r + (PHASE_BITS'(1) << (PHASE_BITS - 2)) : ch_phase_r;
  assign tab_idx   = sin_phase[PHASE_BITS-1 -: SINE_TABLE_BITS];
  assign rom_addr  = tab_idx[QUARTER_BITS] ?
                     QADDR_W'(QUARTER) - QADDR_W'(tab_idx[QUARTER_BITS-1:0]) :
                     QADDR_W'(tab_idx[QUARTER_BITS-1:0]);

  // Stage 1: registered table read and operand capture
  always_ff @(posedge clk) begin
    if (adv) begin
      rom_q_r    <= SINE_QTAB[rom_addr];
      s1_ch_r    <= cnt_r;
      s1_last_r  <= (cnt_r == nlast_r);
      s1_neg_r   <= tab_idx[SINE_TABLE_BITS-1];
      s1_phase_r <= slice_phase_r;
      s1_opa_r   <= (mode_r == MODE_NOISE) ? lfsr_nxt : slice_phase_r;
    end
  end

  // Stage 2: one shared multiplier
  always_comb begin
    mul_a = s1_opa_r;
    mul_b = {1'b0, amp_r};
    if (mode_r == MODE_SINE || mode_r == MODE_COSINE) mul_a = PHASE_BITS'(rom_q_r);
    if (mode_r == MODE_NOISE) mul_b = {amp_r, 1'b1};
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_prod_r  <= PROD_W'(mul_a) * PROD_W'(mul_b);
      s2_ch_r    <= s1_ch_r;
      s2_last_r  <= s1_last_r;
      s2_neg_r   <= s1_neg_r;
      s2_phase_r <= s1_phase_r;
    end
  end

  // Stage 3: sample forming per mode
  assign half_phase  = PHASE_BITS'(1) << (PHASE_BITS - 1);
  assign sine_mag    = SAMPLE_W'(s2_prod_r >> 15);
  // floor of a negative product: round the magnitude up
  assign sine_mag_up = SAMPLE_W'((s2_prod_r + PROD_W'(32767)) >> 15);
  assign noise_wide  = $signed({1'b0, s2_prod_r[PHASE_BITS +: AMP_W+1]})
                       - $signed({2'b00, amp_r});

  always_comb begin
    case (mode_r)
      MODE_NOISE:  sample_nxt = SAMPLE_W'(noise_wide);
      MODE_SINE,
      MODE_COSINE: sample_nxt = s2_neg_r ? -$signed(sine_mag_up) : $signed(sine_mag);
      MODE_FLAT:   sample_nxt = $signed({1'b0, amp_r});
      MODE_SAW:    sample_nxt = $signed({1'b0, s2_prod_r[PHASE_BITS +: AMP_W]});
      MODE_SQUARE: begin
        if (s2_phase_r == '0 || s2_phase_r == half_phase) begin
          sample_nxt = '0;
        end else if (s2_phase_r < half_phase) begin
          sample_nxt = $signed({1'b0, amp_r});
        end else begin
          sample_nxt = -$signed({1'b0, amp_r});
        end
      end
      default:     sample_nxt = '0;
    endcase
  end

  // Stage valids and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      s1_valid_r  <= busy_r;
      s2_valid_r  <= s1_valid_r;
      out_valid_r <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_ch_r     <= s2_ch_r;
      out_sample_r <= sample_nxt;
      out_last_r   <= s2_last_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_channel_index = out_ch_r;
  assign out_sample_value  = out_sample_r;
  assign out_last_of_slice = out_last_r;

endmodule

// ----- tb/sv/mwg_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mwg_checker: sample predictor and scoreboard for the waveform generator
// Mirrors the register writes and accepted slice requests, works out the
// samples each slice should give and compares every accepted output word.
// ----------------------------------------------------------------------------
module mwg_checker
  import mwg_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  input  logic                       in_stall,
  input  logic                       in_slice_request,
  input  logic                       out_valid,
  input  logic                       out_stall,
  input  logic [CH_W-1:0]            out_channel_index,
  input  logic signed [SAMPLE_W-1:0] out_sample_value,
  input  logic                       out_last_of_slice,
  input  logic                       cfg_write_en,
  input  logic [CFG_IDX_W-1:0]       cfg_index,
  input  logic [CFG_DATA_W-1:0]      cfg_data,
  output int                         fail_count,
  output int                         words_due
);

  // Phase geometry
  localparam longint unsigned ANGLE_Q30 = 64'd1686629713;
  localparam longint unsigned RADIAN_48 = 64'd44798133900177;
  localparam logic [PHASE_BITS-1:0] RADIAN_STEP =
    PHASE_BITS'((RADIAN_48 + (64'd1 << (47 - PHASE_BITS))) >> (48 - PHASE_BITS));
  localparam logic [PHASE_BITS-1:0] HALF_TURN = {1'b1, {(PHASE_BITS-1){1'b0}}};
  localparam logic [PHASE_BITS-1:0] QUARTER_TURN = {2'b01, {(PHASE_BITS-2){1'b0}}};
  localparam logic [31:0] LFSR_TAPS = 32'h8020_0003;

  typedef struct packed {
    logic [CH_W-1:0]            chan;
    logic signed [SAMPLE_W-1:0] value;
    logic                       last;
  } sample_word_t;

  sample_word_t due_q[$];
  sample_word_t want;

  // Mirrored registers and generator state
  logic [MODE_W-1:0]     mode_r;
  logic [AMP_W-1:0]      amp_r;
  logic [PHASE_BITS-1:0] step_r;
  logic [CNT_W-1:0]      chans_r;
  logic [PHASE_BITS-1:0] phase_r;
  logic [31:0]           lfsr_r;
  int                    mismatches = 0;

  initial begin
    fail_count = 0;
    words_due  = 0;
  end

  // First-quadrant sine in Q15 from a Q30 Taylor series
  function automatic longint quarter_q15(longint unsigned r);
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint          acc;
    x    = (ANGLE_Q30 * r) >> QUARTER_BITS;
    x2   = (x * x) >> 30;
    term = x;
    acc  = longint'(x);
    for (int n = 1; n <= 6; n++) begin
      term = ((term * x2) >> 30) / longint'((2 * n) * (2 * n + 1));
      if (n % 2 == 1) acc = acc - longint'(term);
      else acc = acc + longint'(term);
    end
    if (acc < 0) acc = 0;
    if (acc > (64'sd1 <<< 30)) acc = 64'sd1 <<< 30;
    return (acc * 32767 + (64'sd1 <<< 29)) >>> 30;
  endfunction

  // Full-cycle table entry by quadrant mirroring
  function automatic longint sine_at(logic [SINE_TABLE_BITS-1:0] idx);
    logic [1:0]              quad;
    logic [QUARTER_BITS-1:0] r;
    longint                  mag;
    quad = idx[SINE_TABLE_BITS-1 -: 2];
    r    = idx[QUARTER_BITS-1:0];
    if (quad[0]) mag = quarter_q15(longint'(QUARTER) - longint'(r));
    else mag = quarter_q15(longint'(r));
    return quad[1] ? -mag : mag;
  endfunction

  // amplitude times Q15 entry, floor division by 2^15
  function automatic longint q15_scale(longint amp, longint t);
    longint p;
    p = amp * t;
    if (p >= 0) return p >>> 15;
    return -((-p + 32767) >>> 15);
  endfunction

  // One sample of channel c at the current phase; noise steps the LFSR
  function automatic longint wave_sample(int c);
    longint                amp;
    longint unsigned       prod;
    logic [PHASE_BITS-1:0] p;
    logic                  lsb;
    amp = longint'(amp_r);
    case (mode_r)
      MODE_NOISE: begin
        lsb    = lfsr_r[0];
        lfsr_r = lfsr_r >> 1;
        if (lsb) lfsr_r = lfsr_r ^ LFSR_TAPS;
        prod = 64'(lfsr_r) * 64'({amp_r, 1'b1});
        return longint'(prod >> 32) - amp;
      end
      MODE_SINE, MODE_COSINE: begin
        p = phase_r + PHASE_BITS'(longint'(c) * longint'(RADIAN_STEP));
        if (mode_r == MODE_COSINE) p = p + QUARTER_TURN;
        return q15_scale(amp, sine_at(p[PHASE_BITS-1 -: SINE_TABLE_BITS]));
      end
      MODE_FLAT: return amp;
      MODE_SAW: return longint'((64'(amp_r) * 64'(phase_r)) >> PHASE_BITS);
      MODE_SQUARE: begin
        if (phase_r == '0 || phase_r == HALF_TURN) return 0;
        return (phase_r < HALF_TURN) ? amp : -amp;
      end
      default: return 0;
    endcase
  endfunction

  // Queue the words of one slice, then advance the phase
  function automatic void queue_slice();
    int           n;
    sample_word_t w;
    n = int'(chans_r);
    if (n == 0) n = 1;
    if (n > MAX_CHANNELS) n = MAX_CHANNELS;
    for (int c = 0; c < n; c++) begin
      w.value = SAMPLE_W'(wave_sample(c));
      w.chan  = CH_W'(c);
      w.last  = (c == n - 1);
      due_q.push_back(w);
    end
    phase_r = phase_r + step_r;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      mode_r  = MODE_NOISE;
      amp_r   = AMP_W'(1);
      step_r  = '0;
      chans_r = CNT_W'(1);
      phase_r = '0;
      lfsr_r  = 32'd1;
      due_q.delete();
    end else begin
      // output side: compare with the oldest expectation
      if (out_valid && !out_stall) begin
        if (due_q.size() == 0) begin
          $error("unexpected word: channel %0d sample %0d",
                 out_channel_index, out_sample_value);
          mismatches++;
        end else begin
          want = due_q.pop_front();
          if (out_channel_index !== want.chan) begin
            $error("channel_index: expected %0d, got %0d", want.chan, out_channel_index);
            mismatches++;
          end
          if (out_sample_value !== want.value) begin
            $error("sample_value: expected %0d, got %0d",
                   $signed(want.value), out_sample_value);
            mismatches++;
          end
          if (out_last_of_slice !== want.last) begin
            $error("last_of_slice: expected %0d, got %0d", want.last, out_last_of_slice);
            mismatches++;
          end
        end
      end
      // input side: a request of 0 is ignored
      if (in_valid && !in_stall && in_slice_request) queue_slice();
      // register writes
      if (cfg_write_en) begin
        case (cfg_index)
          REG_WAVE_MODE:  mode_r  = cfg_data[MODE_W-1:0];
          REG_AMPLITUDE:  amp_r   = cfg_data[AMP_W-1:0];
          REG_PHASE_STEP: step_r  = cfg_data[PHASE_BITS-1:0];
          REG_CHANNELS:   chans_r = cfg_data[CNT_W-1:0];
          default: ;
        endcase
      end
    end
    fail_count <= mismatches;
    words_due  <= due_q.size();
  end

endmodule

// ----- tb/sv/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: testbench top of the multichannel waveform generator
// Drives register settings and slice requests with random gaps and output
// stalls; the checker beside the block predicts and compares every word.
// ----------------------------------------------------------------------------
module tb;
  import mwg_pkg::*;

  // Spare mode codes, expected to give silence
  localparam logic [MODE_W-1:0] MODE_SPARE_A = 3'd6;
  localparam logic [MODE_W-1:0] MODE_SPARE_B = 3'd7;
  localparam int QUIET_LIMIT = 2000;
  localparam int SLICE_TARGET = 330;

  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       in_valid = 1'b0;
  logic                       in_stall;
  logic                       in_slice_request = 1'b0;
  logic                       out_valid;
  logic                       out_stall = 1'b0;
  logic [CH_W-1:0]            out_channel_index;
  logic signed [SAMPLE_W-1:0] out_sample_value;
  logic                       out_last_of_slice;
  logic                       cfg_write_en = 1'b0;
  logic [CFG_IDX_W-1:0]       cfg_index = REG_WAVE_MODE;
  logic [CFG_DATA_W-1:0]      cfg_data = '0;

  int fail_count;
  int words_due;
  int quiet = 0;
  bit calm = 1'b0;
  int requests = 0;
  int phase_no = 0;

  multichannel_waveform_generator dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_slice_request  (in_slice_request),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_channel_index (out_channel_index),
    .out_sample_value  (out_sample_value),
    .out_last_of_slice (out_last_of_slice),
    .cfg_write_en      (cfg_write_en),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  mwg_checker chk (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_slice_request  (in_slice_request),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_channel_index (out_channel_index),
    .out_sample_value  (out_sample_value),
    .out_last_of_slice (out_last_of_slice),
    .cfg_write_en      (cfg_write_en),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .fail_count        (fail_count),
    .words_due         (words_due)
  );

  // 50 MHz clock
  initial begin
    forever #10 clk = ~clk;
  end

  // Random back-pressure on the sample side, none while calm
  always @(posedge clk) begin
    out_stall <= calm ? 1'b0 : ($urandom_range(0, 99) < 30);
  end

  // Watchdog on cycles with no word moving
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet <= 0;
    end else if (quiet >= QUIET_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  // Offer one request word, with an optional gap ahead of it
  task automatic push_word(bit req);
    int gap;
    gap = 0;
    if (!calm && $urandom_range(0, 99) < 30) gap = $urandom_range(1, 10);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_slice_request <= req;
    do @(posedge clk); while (in_stall);
    requests++;
  endtask

  // Wait until every expected word is out and the pipe has settled
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (words_due != 0);
    repeat (8) @(posedge clk);
  endtask

  // Write all four registers while the block is idle
  task automatic set_regs(logic [MODE_W-1:0] mode, logic [AMP_W-1:0] amp,
                          logic [PHASE_BITS-1:0] step, logic [CNT_W-1:0] chans);
    drain();
    cfg_write_en <= 1'b1;
    cfg_index    <= REG_WAVE_MODE;
    cfg_data     <= CFG_DATA_W'(mode);
    @(posedge clk);
    cfg_index    <= REG_AMPLITUDE;
    cfg_data     <= CFG_DATA_W'(amp);
    @(posedge clk);
    cfg_index    <= REG_PHASE_STEP;
    cfg_data     <= CFG_DATA_W'(step);
    @(posedge clk);
    cfg_index    <= REG_CHANNELS;
    cfg_data     <= CFG_DATA_W'(chans);
    @(posedge clk);
    cfg_write_en <= 1'b0;
  endtask

  initial begin
    logic [MODE_W-1:0]     mode;
    logic [AMP_W-1:0]      amp;
    logic [PHASE_BITS-1:0] step;
    logic [CNT_W-1:0]      chans;
    int                    count;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: reset settings, then each mode at its edges
    push_word(1'b1);
    push_word(1'b0);
    set_regs(MODE_SINE, 16'hFFFF, 32'h4000_0000, 4'd8);
    repeat (4) push_word(1'b1);
    set_regs(MODE_COSINE, 16'hFFFF, 32'h8000_0000, 4'd8);
    repeat (2) push_word(1'b1);
    // square through zero, quarter, exactly half and three quarters
    set_regs(MODE_SQUARE, 16'hFFFF, 32'h4000_0000, 4'd3);
    repeat (4) push_word(1'b1);
    // saw with full-width step, channel count of zero
    set_regs(MODE_SAW, 16'hFFFF, 32'hFFFF_FFFF, 4'd0);
    push_word(1'b1);
    push_word(1'b0);
    push_word(1'b1);
    // channel count above the maximum
    set_regs(MODE_FLAT, 16'd1, 32'd0, 4'd15);
    push_word(1'b1);
    set_regs(MODE_SPARE_A, 16'hFFFF, 32'h1234_5678, 4'd8);
    push_word(1'b1);
    set_regs(MODE_SPARE_B, 16'd0, 32'd0, 4'd9);
    push_word(1'b1);
    // zero amplitude noise still steps the LFSR
    set_regs(MODE_NOISE, 16'd0, 32'd7, 4'd2);
    repeat (2) push_word(1'b1);
    set_regs(MODE_NOISE, 16'hFFFF, 32'd0, 4'd8);
    repeat (2) push_word(1'b1);

    // random settings, each followed by a burst of requests
    while (requests < SLICE_TARGET) begin
      if ($urandom_range(0, 15) == 0) mode = $urandom_range(0, 1) ? MODE_SPARE_A : MODE_SPARE_B;
      else mode = MODE_W'($urandom_range(MODE_NOISE, MODE_SQUARE));
      case ($urandom_range(0, 5))
        0:       amp = '0;
        1:       amp = AMP_W'(1);
        2:       amp = '1;
        default: amp = AMP_W'($urandom);
      endcase
      case ($urandom_range(0, 5))
        0:       step = '0;
        1:       step = '1;
        2:       step = 32'h8000_0000;
        3:       step = PHASE_BITS'($urandom_range(0, 65535));
        default: step = PHASE_BITS'($urandom);
      endcase
      if ($urandom_range(0, 4) == 0) chans = CNT_W'($urandom_range(0, 15));
      else chans = CNT_W'($urandom_range(1, MAX_CHANNELS));
      set_regs(mode, amp, step, chans);
      // the fifth round is one long burst without any idling
      calm  = (phase_no == 4);
      count = calm ? 40 : $urandom_range(4, 24);
      for (int k = 0; k < count; k++) push_word($urandom_range(0, 7) != 0);
      calm = 1'b0;
      phase_no++;
    end

    drain();
    if (fail_count == 0 && words_due == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/mwg_pkg.sv
rtl/multichannel_waveform_generator.sv
tb/sv/mwg_checker.sv
tb/sv/tb.sv
